// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL; they use the clk and rst_n of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LMTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lmts_pkg.sv
// Shared types, constants and microcode table of the LED matrix text scroller.
`timescale 1ns / 1ps
package lmts_pkg;

  localparam int DISPLAYS  = 4;
  localparam int ROWS      = 8;
  localparam int ROW_W     = 32;
  localparam int ROW_IDX_W = $clog2(ROWS);
  localparam int COL_W     = 3;
  localparam int PC_W      = 3;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_GLYPH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Display register addresses
  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hB;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [3:0] ADDR_DISPTEST  = 4'hF;
  localparam logic [3:0] ADDR_NONE      = 4'h0;

  // Configuration register indexes (byte address bit 2)
  localparam logic REG_INTENSITY  = 1'b0;
  localparam logic REG_SCAN_LIMIT = 1'b1;

  localparam logic [3:0] INTENSITY_RST  = 4'd7;
  localparam logic [2:0] SCAN_LIMIT_RST = 3'd7;

  typedef enum logic {
    AS_CONST = 1'b0,
    AS_ROW   = 1'b1
  } addr_sel_t;

  typedef enum logic [2:0] {
    DS_ZERO  = 3'd0,
    DS_ONE   = 3'd1,
    DS_SCAN  = 3'd2,
    DS_INTEN = 3'd3,
    DS_ROW   = 3'd4
  } data_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,  // fall through
    SEQ_END  = 2'd1,  // program done
    SEQ_ROWS = 2'd2,  // repeat over rows, then done
    SEQ_COLS = 2'd3   // repeat over rows, then jump back per column
  } seq_t;

  typedef struct packed {
    logic            emit;
    addr_sel_t       addr_sel;
    logic [3:0]      cmd_addr;
    data_sel_t       data_sel;
    logic            shift;
    seq_t            seq;
    logic [PC_W-1:0] target;
  } cw_t;

  localparam logic [PC_W-1:0] PC_INIT  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_CLEAR = PC_W'(5);
  localparam logic [PC_W-1:0] PC_GLYPH = PC_W'(6);

  function automatic cw_t ucode(logic [PC_W-1:0] pc);
    cw_t cw;
    unique case (pc)
      PC_W'(0): cw = '{1'b1, AS_CONST, ADDR_SCANLIMIT, DS_SCAN,  1'b0, SEQ_NEXT, PC_INIT};
      PC_W'(1): cw = '{1'b1, AS_CONST, ADDR_DECODE,    DS_ZERO,  1'b0, SEQ_NEXT, PC_INIT};
      PC_W'(2): cw = '{1'b1, AS_CONST, ADDR_SHUTDOWN,  DS_ONE,   1'b0, SEQ_NEXT, PC_INIT};
      PC_W'(3): cw = '{1'b1, AS_CONST, ADDR_DISPTEST,  DS_ZERO,  1'b0, SEQ_NEXT, PC_INIT};
      PC_W'(4): cw = '{1'b1, AS_CONST, ADDR_INTENSITY, DS_INTEN, 1'b0, SEQ_NEXT, PC_INIT};
      PC_W'(5): cw = '{1'b1, AS_ROW,   ADDR_NONE,      DS_ZERO,  1'b0, SEQ_ROWS, PC_INIT};
      PC_W'(6): cw = '{1'b0, AS_ROW,   ADDR_NONE,      DS_ZERO,  1'b1, SEQ_NEXT, PC_INIT};
      PC_W'(7): cw = '{1'b1, AS_ROW,   ADDR_NONE,      DS_ROW,   1'b0, SEQ_COLS, PC_GLYPH};
      default:  cw = '{1'b0, AS_CONST, ADDR_NONE,      DS_ZERO,  1'b0, SEQ_END,  PC_INIT};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/lmts_in_if.sv
// Input request channel of the text scroller.
`timescale 1ns / 1ps
interface lmts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] glyph_bits;
  logic        new_text;

  modport source (output valid, opcode, glyph_bits, new_text, input ready);
  modport sink   (input valid, opcode, glyph_bits, new_text, output ready);
endinterface

// File: rtl/lmts_out_if.sv
// Frame output channel of the text scroller.
`timescale 1ns / 1ps
interface lmts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] register_address;
  logic [7:0] byte_display0;
  logic [7:0] byte_display1;
  logic [7:0] byte_display2;
  logic [7:0] byte_display3;
  logic       last_of_run;

  modport source (output valid, register_address, byte_display0, byte_display1,
                  byte_display2, byte_display3, last_of_run, input ready);
  modport sink   (input valid, register_address, byte_display0, byte_display1,
                  byte_display2, byte_display3, last_of_run, output ready);
endinterface

// File: rtl/led_matrix_text_scroller_core.sv
// Scrolling-text engine for four chained 8x8 LED matrix drivers.
// Use: requests arrive on in_if (valid/ready); each one yields a run of display
// frames on out_if (register address plus one data byte per display), the last
// frame of a run flagged by last_of_run. Opcode 0 sends five setup frames and
// eight clearing frames (13 frames), opcode 1 sends eight clearing frames,
// opcode 2 scrolls one glyph in and sends 64 row frames; opcode 3 is dropped.
// The cfg_ APB port holds intensity (0x0) and scan limit (0x4); write only idle.
// Timing: a microcode step counter walks an eight-word control ROM, one step per
// cycle unless a frame step waits on a stalled output register. Each frame takes
// one step and each glyph column one extra shift step; the first frame is loaded
// by the first emitting step (for a glyph, behind its first shift step), and
// in_if.ready rises in the same cycle that the last frame is loaded.
// One request is in work at a time; in_if.ready is low meanwhile.
// Reset: rows cleared, intensity and scan limit back to 7, no frame pending.
// Stall: a held frame stays in the output register and the sequencer waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module led_matrix_text_scroller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  lmts_in_if.sink                        in_if,
  lmts_out_if.source                     out_if,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lmts_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [lmts_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [lmts_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  logic [lmts_pkg::ROW_W-1:0]     rows_r [lmts_pkg::ROWS];
  logic [lmts_pkg::ROW_W-1:0]     rows_nxt [lmts_pkg::ROWS];
  logic [63:0]                    glyph_r;
  logic [lmts_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic [lmts_pkg::ROW_IDX_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [lmts_pkg::COL_W-1:0]     col_cnt_r, col_cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic [3:0]                     intensity_r;
  logic [2:0]                     scan_limit_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [3:0]                     out_addr_r;
  logic [7:0]                     out_bytes_r [4];
  logic                           out_last_r;

  lmts_pkg::cw_t                  cw;
  lmts_pkg::opcode_t              in_op;
  logic                           in_acc;
  logic                           out_free;
  logic                           step_go;
  logic                           run_end;
  logic                           load;
  logic [3:0]                     frame_addr;
  logic [7:0]                     cmd_data;
  logic [7:0]                     frame_bytes [4];
  logic [lmts_pkg::ROW_W-1:0]     row_sel;
  logic [7:0]                     col_byte;
  logic                           cfg_wr;

  assign cw       = lmts_pkg::ucode(pc_r);
  assign in_op    = lmts_pkg::opcode_t'(in_if.opcode);
  assign in_if.ready = !busy_r;
  assign in_acc   = in_if.valid && !busy_r;
  assign out_free = !out_valid_r || out_if.ready;
  assign step_go  = busy_r && (!cw.emit || out_free);
  assign load     = step_go && cw.emit;
  assign row_sel  = rows_r[row_cnt_r];
  assign col_byte = glyph_r[{col_cnt_r, 3'b000} +: 8];

  // Sequencer: step counter with row/column loop counters
  always_comb begin
    pc_nxt      = pc_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    busy_nxt    = busy_r;
    run_end     = 1'b0;
    if (in_acc) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
      case (in_op)
        lmts_pkg::OP_INIT: begin
          pc_nxt   = lmts_pkg::PC_INIT;
          busy_nxt = 1'b1;
        end
        lmts_pkg::OP_CLEAR: begin
          pc_nxt   = lmts_pkg::PC_CLEAR;
          busy_nxt = 1'b1;
        end
        lmts_pkg::OP_GLYPH: begin
          pc_nxt   = lmts_pkg::PC_GLYPH;
          busy_nxt = 1'b1;
        end
        default: busy_nxt = 1'b0;
      endcase
    end else if (step_go) begin
      unique case (cw.seq)
        lmts_pkg::SEQ_NEXT: pc_nxt = pc_r + lmts_pkg::PC_W'(1);
        lmts_pkg::SEQ_END:  run_end = 1'b1;
        lmts_pkg::SEQ_ROWS: begin
          row_cnt_nxt = row_cnt_r + lmts_pkg::ROW_IDX_W'(1);
          if (&row_cnt_r) run_end = 1'b1;
        end
        lmts_pkg::SEQ_COLS: begin
          row_cnt_nxt = row_cnt_r + lmts_pkg::ROW_IDX_W'(1);
          if (&row_cnt_r) begin
            if (&col_cnt_r) begin
              run_end = 1'b1;
            end else begin
              col_cnt_nxt = col_cnt_r + lmts_pkg::COL_W'(1);
              pc_nxt      = cw.target;
            end
          end
        end
        default: run_end = 1'b1;
      endcase
      if (run_end) busy_nxt = 1'b0;
    end
  end

  // Row store: cleared on init/clear/new text, shifted on a column step
  always_comb begin
    for (int r = 0; r < lmts_pkg::ROWS; r++) begin
      rows_nxt[r] = rows_r[r];
      if (in_acc && (in_op == lmts_pkg::OP_INIT || in_op == lmts_pkg::OP_CLEAR ||
                     (in_op == lmts_pkg::OP_GLYPH && in_if.new_text))) begin
        rows_nxt[r] = '0;
      end else if (step_go && cw.shift) begin
        rows_nxt[r] = {rows_r[r][lmts_pkg::ROW_W-2:0], col_byte[r]};
      end
    end
  end

  // Frame datapath
  always_comb begin
    unique case (cw.data_sel)
      lmts_pkg::DS_ONE:   cmd_data = 8'd1;
      lmts_pkg::DS_SCAN:  cmd_data = {5'd0, scan_limit_r};
      lmts_pkg::DS_INTEN: cmd_data = {4'd0, intensity_r};
      default:            cmd_data = 8'd0;
    endcase
    frame_addr = (cw.addr_sel == lmts_pkg::AS_ROW) ?
                 ({1'b0, row_cnt_r} + 4'd1) : cw.cmd_addr;
    for (int d = 0; d < 4; d++) begin
      frame_bytes[d] = 8'd0;
      if (d < lmts_pkg::DISPLAYS) begin
        if (cw.data_sel == lmts_pkg::DS_ROW) begin
          // display 0 takes the most significant byte of the row
          if ((lmts_pkg::DISPLAYS - 1 - d) * 8 < lmts_pkg::ROW_W) begin
            frame_bytes[d] = 8'(row_sel >> ((lmts_pkg::DISPLAYS - 1 - d) * 8));
          end
        end else begin
          frame_bytes[d] = cmd_data;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= lmts_pkg::PC_INIT;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      intensity_r  <= lmts_pkg::INTENSITY_RST;
      scan_limit_r <= lmts_pkg::SCAN_LIMIT_RST;
      for (int r = 0; r < lmts_pkg::ROWS; r++) rows_r[r] <= '0;
    end else begin
      pc_r        <= pc_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      for (int r = 0; r < lmts_pkg::ROWS; r++) rows_r[r] <= rows_nxt[r];
      if (cfg_wr) begin
        if (cfg_paddr[2] == lmts_pkg::REG_INTENSITY) intensity_r <= cfg_pwdata[3:0];
        else scan_limit_r <= cfg_pwdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) glyph_r <= in_if.glyph_bits;
    if (load) begin
      out_addr_r <= frame_addr;
      out_last_r <= run_end;
      for (int d = 0; d < 4; d++) out_bytes_r[d] <= frame_bytes[d];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == lmts_pkg::REG_SCAN_LIMIT) ?
                      {29'd0, scan_limit_r} : {28'd0, intensity_r};

  assign out_if.valid            = out_valid_r;
  assign out_if.register_address = out_addr_r;
  assign out_if.byte_display0    = out_bytes_r[0];
  assign out_if.byte_display1    = out_bytes_r[1];
  assign out_if.byte_display2    = out_bytes_r[2];
  assign out_if.byte_display3    = out_bytes_r[3];
  assign out_if.last_of_run      = out_last_r;

  // a stalled frame stays valid until the receiver takes it
  `LMTS_ASSERT_NXT(a_out_hold, out_valid_r && !out_if.ready, out_valid_r,
                   "frame dropped while receiver stalled")
  // glyph column step always starts at the first row
  `LMTS_ASSERT_IMP(a_col_start, busy_r && pc_r == lmts_pkg::PC_GLYPH, row_cnt_r == '0,
                   "column shift step with nonzero row count")
  `LMTS_ASSERT_NXT(a_op_none, in_acc && in_op == lmts_pkg::OP_NONE, !busy_r,
                   "unused opcode started a run")
  `LMTS_ASSERT_NXT(a_op_run, in_acc && in_op != lmts_pkg::OP_NONE, busy_r,
                   "valid opcode did not start a run")

endmodule
